>>> rtl/core/fjot_pkg.sv
package fjot_pkg;

  // Parser phases
  typedef enum logic [3:0] {
    PH_START    = 4'd0,
    PH_OPENED   = 4'd1,
    PH_KEYDUE   = 4'd2,
    PH_STR      = 4'd3,
    PH_ESC      = 4'd4,
    PH_HEX      = 4'd5,
    PH_LOBS     = 4'd6,
    PH_LOU      = 4'd7,
    PH_LOHEX    = 4'd8,
    PH_COLON    = 4'd9,
    PH_VALDUE   = 4'd10,
    PH_BARE     = 4'd11,
    PH_AFTERVAL = 4'd12,
    PH_TAIL     = 4'd13,
    PH_ERR      = 4'd14
  } phase_t;

  // Status codes reported on every result
  typedef enum logic [3:0] {
    ST_RUNNING      = 4'd0,
    ST_DONE_OK      = 4'd1,
    ST_NOT_OBJECT   = 4'd2,
    ST_KEY_EXPECTED = 4'd3,
    ST_UNCLOSED     = 4'd4,
    ST_CONTROL_CHAR = 4'd5,
    ST_CUT_ESCAPE   = 4'd6,
    ST_BAD_HEX      = 4'd7,
    ST_HALF_SURR    = 4'd8,
    ST_BAD_ESCAPE   = 4'd9,
    ST_NO_VALUE     = 4'd10,
    ST_NESTED       = 4'd11,
    ST_SEP_EXPECTED = 4'd12,
    ST_TRAILING     = 4'd13
  } status_t;

  // Token kinds
  localparam logic [1:0] KIND_KEY  = 2'd0;
  localparam logic [1:0] KIND_STR  = 2'd1;
  localparam logic [1:0] KIND_BARE = 2'd2;

  // Characters of interest
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_LOW_B   = 8'h62;
  localparam logic [7:0] CH_LOW_F   = 8'h66;
  localparam logic [7:0] CH_LOW_N   = 8'h6E;
  localparam logic [7:0] CH_LOW_R   = 8'h72;
  localparam logic [7:0] CH_LOW_T   = 8'h74;
  localparam logic [7:0] CH_LOW_U   = 8'h75;
  localparam logic [7:0] CH_CTRL_LIM = 8'h20;

  // Surrogate tags in the upper six bits of a 16-bit code unit
  localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
  localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic [1:0] token_kind;
    logic       token_end;
    status_t    status;
    logic       last_of_run;
  } out_item_t;

endpackage

>>> rtl/core/flat_json_object_tokenizer_top.sv
// Flat JSON object tokenizer. Feed the text one byte per transfer and close it
// with an end-of-text transfer, which reports the final status and returns the
// parser to its reset state. Each input transfer yields one to four result
// transfers; the last carries last_of_run. Plain bytes, token ends and silent
// bytes give one result, so with out_stall low one byte is taken per cycle; an
// escape decoding to n UTF-8 bytes holds the result register until its n
// results leave. Parser state advances as a byte is taken; a byte's results
// sit in a single result register drained one per cycle with out_stall low;
// the next byte is taken in the same cycle as the last result before it leaves.
module flat_json_object_tokenizer_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fjot_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fjot_pkg::out_item_t  out_data
);

  // Parser state
  fjot_pkg::phase_t  phase_r, phase_nxt;
  fjot_pkg::status_t sticky_r, sticky_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [15:0]       acc_r, acc_nxt;
  logic [9:0]        hs_r, hs_nxt;
  logic [1:0]        hcnt_r, hcnt_nxt;

  // Result register
  logic              bvalid_r, bvalid_nxt;
  logic [3:0][7:0]   bytes_r, bytes_nxt;
  logic [1:0]        last_r, last_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic              has_r, has_nxt;
  logic              end_r, end_nxt;
  logic [1:0]        rkind_r, rkind_nxt;
  fjot_pkg::status_t rstat_r, rstat_nxt;

  // Step decode
  logic [7:0]        c;
  logic              blank;
  logic              hex_ok;
  logic [3:0]        hex_v;
  logic [15:0]       acc_new;
  logic              raw_en;
  logic              emit_en;
  logic              tend;
  logic [20:0]       cp;
  logic [3:0][7:0]   enc_bytes;
  logic [1:0]        enc_last;
  fjot_pkg::status_t end_stat;

  logic in_acc;
  logic out_acc;
  logic out_last;

  assign c = in_data.text_byte;
  assign blank = (c == fjot_pkg::CH_SPACE) || (c == fjot_pkg::CH_TAB) ||
                 (c == fjot_pkg::CH_CR) || (c == fjot_pkg::CH_LF);

  // Hex digit decode
  always_comb begin
    hex_ok = 1'b1;
    hex_v  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_v = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      hex_v = c[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign acc_new = {acc_r[11:0], hex_v};

  fjot_utf8_enc u_enc (
    .cp        (cp),
    .enc_bytes (enc_bytes),
    .enc_last  (enc_last)
  );

  // Status reported at end of text
  always_comb begin
    unique case (phase_r)
      fjot_pkg::PH_START:    end_stat = fjot_pkg::ST_NOT_OBJECT;
      fjot_pkg::PH_OPENED,
      fjot_pkg::PH_KEYDUE:   end_stat = fjot_pkg::ST_KEY_EXPECTED;
      fjot_pkg::PH_STR:      end_stat = fjot_pkg::ST_UNCLOSED;
      fjot_pkg::PH_ESC:      end_stat = fjot_pkg::ST_CUT_ESCAPE;
      fjot_pkg::PH_HEX:      end_stat = fjot_pkg::ST_BAD_HEX;
      fjot_pkg::PH_LOBS,
      fjot_pkg::PH_LOU,
      fjot_pkg::PH_LOHEX:    end_stat = fjot_pkg::ST_HALF_SURR;
      fjot_pkg::PH_COLON,
      fjot_pkg::PH_VALDUE:   end_stat = fjot_pkg::ST_NO_VALUE;
      fjot_pkg::PH_BARE,
      fjot_pkg::PH_AFTERVAL: end_stat = fjot_pkg::ST_SEP_EXPECTED;
      fjot_pkg::PH_TAIL:     end_stat = fjot_pkg::ST_DONE_OK;
      default:               end_stat = sticky_r;
    endcase
  end

  // Grammar step: next parser state and what the byte produces
  always_comb begin
    phase_nxt  = phase_r;
    sticky_nxt = sticky_r;
    kind_nxt   = kind_r;
    acc_nxt    = acc_r;
    hs_nxt     = hs_r;
    hcnt_nxt   = hcnt_r;
    raw_en     = 1'b0;
    emit_en    = 1'b0;
    tend       = 1'b0;
    cp         = '0;

    if (in_data.end_of_text) begin
      phase_nxt  = fjot_pkg::PH_START;
      sticky_nxt = fjot_pkg::ST_RUNNING;
      kind_nxt   = fjot_pkg::KIND_KEY;
      acc_nxt    = '0;
      hs_nxt     = '0;
      hcnt_nxt   = '0;
    end else begin
      unique case (phase_r)
        fjot_pkg::PH_START: begin
          if (!blank) begin
            if (c == fjot_pkg::CH_LBRACE) begin
              phase_nxt = fjot_pkg::PH_OPENED;
            end else begin
              phase_nxt  = fjot_pkg::PH_ERR;
              sticky_nxt = fjot_pkg::ST_NOT_OBJECT;
            end
          end
        end
        fjot_pkg::PH_OPENED,
        fjot_pkg::PH_KEYDUE: begin
          if (!blank) begin
            if (c == fjot_pkg::CH_RBRACE && phase_r == fjot_pkg::PH_OPENED) begin
              phase_nxt = fjot_pkg::PH_TAIL;
            end else if (c == fjot_pkg::CH_QUOTE) begin
              kind_nxt  = fjot_pkg::KIND_KEY;
              phase_nxt = fjot_pkg::PH_STR;
            end else begin
              phase_nxt  = fjot_pkg::PH_ERR;
              sticky_nxt = fjot_pkg::ST_KEY_EXPECTED;
            end
          end
        end
        fjot_pkg::PH_STR: begin
          if (c == fjot_pkg::CH_QUOTE) begin
            tend      = 1'b1;
            phase_nxt = (kind_r == fjot_pkg::KIND_KEY) ? fjot_pkg::PH_COLON
                                                        : fjot_pkg::PH_AFTERVAL;
          end else if (c < fjot_pkg::CH_CTRL_LIM) begin
            phase_nxt  = fjot_pkg::PH_ERR;
            sticky_nxt = fjot_pkg::ST_CONTROL_CHAR;
          end else if (c == fjot_pkg::CH_BSLASH) begin
            phase_nxt = fjot_pkg::PH_ESC;
          end else begin
            raw_en = 1'b1;
          end
        end
        fjot_pkg::PH_ESC: begin
          phase_nxt = fjot_pkg::PH_STR;
          emit_en   = 1'b1;
          priority case (c)
            fjot_pkg::CH_QUOTE,
            fjot_pkg::CH_BSLASH,
            fjot_pkg::CH_SLASH: cp = {13'd0, c};
            fjot_pkg::CH_LOW_B: cp = {13'd0, fjot_pkg::CH_BS};
            fjot_pkg::CH_LOW_F: cp = {13'd0, fjot_pkg::CH_FF};
            fjot_pkg::CH_LOW_N: cp = {13'd0, fjot_pkg::CH_LF};
            fjot_pkg::CH_LOW_R: cp = {13'd0, fjot_pkg::CH_CR};
            fjot_pkg::CH_LOW_T: cp = {13'd0, fjot_pkg::CH_TAB};
            fjot_pkg::CH_LOW_U: begin
              emit_en   = 1'b0;
              acc_nxt   = '0;
              hcnt_nxt  = '0;
              phase_nxt = fjot_pkg::PH_HEX;
            end
            default: begin
              emit_en    = 1'b0;
              phase_nxt  = fjot_pkg::PH_ERR;
              sticky_nxt = fjot_pkg::ST_BAD_ESCAPE;
            end
          endcase
        end
        fjot_pkg::PH_HEX,
        fjot_pkg::PH_LOHEX: begin
          if (!hex_ok) begin
            phase_nxt  = fjot_pkg::PH_ERR;
            sticky_nxt = (phase_r == fjot_pkg::PH_HEX) ? fjot_pkg::ST_BAD_HEX
                                                        : fjot_pkg::ST_HALF_SURR;
          end else begin
            acc_nxt  = acc_new;
            hcnt_nxt = hcnt_r + 2'd1;
            if (hcnt_r == 2'd3) begin
              if (phase_r == fjot_pkg::PH_HEX) begin
                if (acc_new[15:10] == fjot_pkg::SURR_HIGH_TAG) begin
                  hs_nxt    = acc_new[9:0];
                  phase_nxt = fjot_pkg::PH_LOBS;
                end else if (acc_new[15:10] == fjot_pkg::SURR_LOW_TAG) begin
                  phase_nxt  = fjot_pkg::PH_ERR;
                  sticky_nxt = fjot_pkg::ST_HALF_SURR;
                end else begin
                  phase_nxt = fjot_pkg::PH_STR;
                  emit_en   = 1'b1;
                  cp        = {5'd0, acc_new};
                end
              end else begin
                if (acc_new[15:10] != fjot_pkg::SURR_LOW_TAG) begin
                  phase_nxt  = fjot_pkg::PH_ERR;
                  sticky_nxt = fjot_pkg::ST_HALF_SURR;
                end else begin
                  phase_nxt = fjot_pkg::PH_STR;
                  emit_en   = 1'b1;
                  cp        = fjot_pkg::SUPP_BASE + {1'b0, hs_r, acc_new[9:0]};
                end
              end
            end
          end
        end
        fjot_pkg::PH_LOBS: begin
          if (c == fjot_pkg::CH_BSLASH) begin
            phase_nxt = fjot_pkg::PH_LOU;
          end else begin
            phase_nxt  = fjot_pkg::PH_ERR;
            sticky_nxt = fjot_pkg::ST_HALF_SURR;
          end
        end
        fjot_pkg::PH_LOU: begin
          if (c == fjot_pkg::CH_LOW_U) begin
            acc_nxt   = '0;
            hcnt_nxt  = '0;
            phase_nxt = fjot_pkg::PH_LOHEX;
          end else begin
            phase_nxt  = fjot_pkg::PH_ERR;
            sticky_nxt = fjot_pkg::ST_HALF_SURR;
          end
        end
        fjot_pkg::PH_COLON: begin
          if (!blank) begin
            if (c == fjot_pkg::CH_COLON) begin
              phase_nxt = fjot_pkg::PH_VALDUE;
            end else begin
              phase_nxt  = fjot_pkg::PH_ERR;
              sticky_nxt = fjot_pkg::ST_NO_VALUE;
            end
          end
        end
        fjot_pkg::PH_VALDUE: begin
          if (!blank) begin
            if (c == fjot_pkg::CH_QUOTE) begin
              kind_nxt  = fjot_pkg::KIND_STR;
              phase_nxt = fjot_pkg::PH_STR;
            end else if (c == fjot_pkg::CH_LBRACE || c == fjot_pkg::CH_LBRACK) begin
              phase_nxt  = fjot_pkg::PH_ERR;
              sticky_nxt = fjot_pkg::ST_NESTED;
            end else if (c == fjot_pkg::CH_COMMA || c == fjot_pkg::CH_RBRACE) begin
              phase_nxt  = fjot_pkg::PH_ERR;
              sticky_nxt = fjot_pkg::ST_NO_VALUE;
            end else begin
              kind_nxt  = fjot_pkg::KIND_BARE;
              phase_nxt = fjot_pkg::PH_BARE;
              raw_en    = 1'b1;
            end
          end
        end
        fjot_pkg::PH_BARE: begin
          if (c == fjot_pkg::CH_COMMA) begin
            tend      = 1'b1;
            phase_nxt = fjot_pkg::PH_KEYDUE;
          end else if (c == fjot_pkg::CH_RBRACE) begin
            tend      = 1'b1;
            phase_nxt = fjot_pkg::PH_TAIL;
          end else if (blank) begin
            tend      = 1'b1;
            phase_nxt = fjot_pkg::PH_AFTERVAL;
          end else begin
            raw_en = 1'b1;
          end
        end
        fjot_pkg::PH_AFTERVAL: begin
          if (!blank) begin
            if (c == fjot_pkg::CH_COMMA) begin
              phase_nxt = fjot_pkg::PH_KEYDUE;
            end else if (c == fjot_pkg::CH_RBRACE) begin
              phase_nxt = fjot_pkg::PH_TAIL;
            end else begin
              phase_nxt  = fjot_pkg::PH_ERR;
              sticky_nxt = fjot_pkg::ST_SEP_EXPECTED;
            end
          end
        end
        fjot_pkg::PH_TAIL: begin
          if (!blank) begin
            phase_nxt  = fjot_pkg::PH_ERR;
            sticky_nxt = fjot_pkg::ST_TRAILING;
          end
        end
        default: begin
          // error phase: bytes are dropped until end of text
        end
      endcase
    end
  end

  // Handshakes
  assign out_acc  = bvalid_r && !out_stall;
  assign out_last = (idx_r == last_r);
  assign in_stall = bvalid_r && !(out_acc && out_last);
  assign in_acc   = in_valid && !in_stall;

  // Result register load and drain
  always_comb begin
    bvalid_nxt = bvalid_r;
    bytes_nxt  = bytes_r;
    last_nxt   = last_r;
    idx_nxt    = idx_r;
    has_nxt    = has_r;
    end_nxt    = end_r;
    rkind_nxt  = rkind_r;
    rstat_nxt  = rstat_r;
    if (in_acc) begin
      bvalid_nxt = 1'b1;
      idx_nxt    = 2'd0;
      has_nxt    = raw_en || emit_en;
      end_nxt    = tend;
      rkind_nxt  = (raw_en || emit_en || tend) ? kind_nxt : fjot_pkg::KIND_KEY;
      rstat_nxt  = in_data.end_of_text ? end_stat : sticky_nxt;
      if (emit_en) begin
        bytes_nxt = enc_bytes;
        last_nxt  = enc_last;
      end else begin
        bytes_nxt = {24'd0, (raw_en ? c : 8'd0)};
        last_nxt  = 2'd0;
      end
    end else if (out_acc) begin
      if (out_last) begin
        bvalid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= fjot_pkg::PH_START;
      sticky_r <= fjot_pkg::ST_RUNNING;
      kind_r   <= fjot_pkg::KIND_KEY;
      acc_r    <= '0;
      hs_r     <= '0;
      hcnt_r   <= '0;
      bvalid_r <= 1'b0;
      idx_r    <= '0;
      last_r   <= '0;
    end else begin
      if (in_acc) begin
        phase_r  <= phase_nxt;
        sticky_r <= sticky_nxt;
        kind_r   <= kind_nxt;
        acc_r    <= acc_nxt;
        hs_r     <= hs_nxt;
        hcnt_r   <= hcnt_nxt;
      end
      bvalid_r <= bvalid_nxt;
      idx_r    <= idx_nxt;
      last_r   <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    has_r   <= has_nxt;
    end_r   <= end_nxt;
    rkind_r <= rkind_nxt;
    rstat_r <= rstat_nxt;
  end

  // Result channel
  assign out_valid              = bvalid_r;
  assign out_data.out_byte      = bytes_r[idx_r];
  assign out_data.has_byte      = has_r;
  assign out_data.token_kind    = rkind_r;
  assign out_data.token_end     = end_r;
  assign out_data.status        = rstat_r;
  assign out_data.last_of_run   = out_last;

  // Checks
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && bvalid_r |-> out_acc && out_last)
    else $error("new byte taken while results still pending");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    bvalid_r |-> idx_r <= last_r)
    else $error("result index past last result");

  a_byte_or_end: assert property (@(posedge clk) disable iff (!rst_n)
    bvalid_r |-> !(has_r && end_r))
    else $error("result carries both a byte and a token end");

  a_multi_is_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    bvalid_r && last_r != 2'd0 |-> has_r)
    else $error("multi-result run without data bytes");

endmodule

>>> rtl/core/fjot_utf8_enc.sv
module fjot_utf8_enc (
  input  logic [20:0]      cp,
  output logic [3:0][7:0]  enc_bytes,
  output logic [1:0]       enc_last
);

  // Byte 0 is sent first; enc_last is the index of the final byte
  always_comb begin
    enc_bytes = '0;
    enc_last  = 2'd0;
    if (cp[20:7] == '0) begin
      enc_bytes[0] = cp[7:0];
      enc_last     = 2'd0;
    end else if (cp[20:11] == '0) begin
      enc_bytes[0] = {3'b110, cp[10:6]};
      enc_bytes[1] = {2'b10, cp[5:0]};
      enc_last     = 2'd1;
    end else if (cp[20:16] == '0) begin
      enc_bytes[0] = {4'b1110, cp[15:12]};
      enc_bytes[1] = {2'b10, cp[11:6]};
      enc_bytes[2] = {2'b10, cp[5:0]};
      enc_last     = 2'd2;
    end else begin
      enc_bytes[0] = {5'b11110, cp[20:18]};
      enc_bytes[1] = {2'b10, cp[17:12]};
      enc_bytes[2] = {2'b10, cp[11:6]};
      enc_bytes[3] = {2'b10, cp[5:0]};
      enc_last     = 2'd3;
    end
  end

endmodule

>>> tb/tb_flat_json_object_tokenizer_top.sv
`timescale 1ns / 100ps

module tb_flat_json_object_tokenizer_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 200;
  localparam int PHASE_ITEMS    = 30;
  localparam int END_CYCLES     = 20;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  fjot_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  fjot_pkg::out_item_t out_data;

  flat_json_object_tokenizer_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bench state
  fjot_pkg::in_item_t  text_items[$];       // bytes waiting to be offered
  fjot_pkg::out_item_t expected_tokens[$];  // predicted result transfers, oldest first
  fjot_pkg::out_item_t run_buf[$];          // results of the byte being predicted
  logic [7:0]          text_buf[$];         // text under construction
  int                  in_idle_pct = 0;
  int                  out_stall_pct = 0;
  int                  hold_req = 0;
  int                  hold_served;
  int                  hold_left;
  int                  idle_cycles;
  int                  mismatches = 0;
  int                  items_accepted = 0;
  int                  results_checked = 0;
  int                  texts_queued = 0;
  logic [15:0]         status_seen = '0;
  fjot_pkg::out_item_t want;

  // Parser shadow state
  fjot_pkg::phase_t  parse_ph = fjot_pkg::PH_START;
  logic [1:0]        cur_kind = fjot_pkg::KIND_KEY;
  logic [15:0]       hex_acc = '0;
  logic [9:0]        hi_surr = '0;
  logic [2:0]        hex_cnt = '0;
  logic              val_nonempty = 1'b0;
  fjot_pkg::status_t sticky = fjot_pkg::ST_RUNNING;

  function automatic bit is_blank(logic [7:0] c);
    return c == fjot_pkg::CH_SPACE || c == fjot_pkg::CH_TAB ||
           c == fjot_pkg::CH_CR || c == fjot_pkg::CH_LF;
  endfunction

  function automatic int hex_value(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  function automatic void clear_parser();
    parse_ph = fjot_pkg::PH_START;
    cur_kind = fjot_pkg::KIND_KEY;
    hex_acc = '0;
    hi_surr = '0;
    hex_cnt = '0;
    val_nonempty = 1'b0;
    sticky = fjot_pkg::ST_RUNNING;
  endfunction

  function automatic void push_result(logic [7:0] b, logic has, logic tend);
    fjot_pkg::out_item_t r;
    r = '0;
    r.out_byte = has ? b : 8'h00;
    r.has_byte = has;
    r.token_kind = (has || tend) ? cur_kind : fjot_pkg::KIND_KEY;
    r.token_end = tend;
    run_buf.push_back(r);
  endfunction

  function automatic void stop_on(fjot_pkg::status_t code);
    sticky = code;
    parse_ph = fjot_pkg::PH_ERR;
  endfunction

  function automatic void open_token(logic [1:0] kind, fjot_pkg::phase_t ph);
    cur_kind = kind;
    val_nonempty = 1'b0;
    parse_ph = ph;
  endfunction

  // Code point to UTF-8, one result per byte
  function automatic void emit_utf8(int unsigned cp);
    if (cp < 32'h80) begin
      push_result(cp[7:0], 1'b1, 1'b0);
    end else if (cp < 32'h800) begin
      push_result(8'hC0 | cp[10:6], 1'b1, 1'b0);
      push_result(8'h80 | cp[5:0], 1'b1, 1'b0);
    end else if (cp < 32'h10000) begin
      push_result(8'hE0 | cp[15:12], 1'b1, 1'b0);
      push_result(8'h80 | cp[11:6], 1'b1, 1'b0);
      push_result(8'h80 | cp[5:0], 1'b1, 1'b0);
    end else begin
      push_result(8'hF0 | cp[20:18], 1'b1, 1'b0);
      push_result(8'h80 | cp[17:12], 1'b1, 1'b0);
      push_result(8'h80 | cp[11:6], 1'b1, 1'b0);
      push_result(8'h80 | cp[5:0], 1'b1, 1'b0);
    end
    val_nonempty = 1'b1;
  endfunction

  function automatic void parse_byte(logic [7:0] c);
    int h;
    case (parse_ph)
      fjot_pkg::PH_START: begin
        if (!is_blank(c)) begin
          if (c == fjot_pkg::CH_LBRACE) parse_ph = fjot_pkg::PH_OPENED;
          else stop_on(fjot_pkg::ST_NOT_OBJECT);
        end
      end
      fjot_pkg::PH_OPENED, fjot_pkg::PH_KEYDUE: begin
        if (!is_blank(c)) begin
          if (c == fjot_pkg::CH_RBRACE && parse_ph == fjot_pkg::PH_OPENED)
            parse_ph = fjot_pkg::PH_TAIL;
          else if (c == fjot_pkg::CH_QUOTE)
            open_token(fjot_pkg::KIND_KEY, fjot_pkg::PH_STR);
          else stop_on(fjot_pkg::ST_KEY_EXPECTED);
        end
      end
      fjot_pkg::PH_STR: begin
        if (c == fjot_pkg::CH_QUOTE) begin
          push_result(8'h00, 1'b0, 1'b1);
          parse_ph = (cur_kind == fjot_pkg::KIND_KEY) ? fjot_pkg::PH_COLON
                                                      : fjot_pkg::PH_AFTERVAL;
        end else if (c < fjot_pkg::CH_CTRL_LIM) begin
          stop_on(fjot_pkg::ST_CONTROL_CHAR);
        end else if (c == fjot_pkg::CH_BSLASH) begin
          parse_ph = fjot_pkg::PH_ESC;
        end else begin
          push_result(c, 1'b1, 1'b0);
          val_nonempty = 1'b1;
        end
      end
      fjot_pkg::PH_ESC: begin
        parse_ph = fjot_pkg::PH_STR;
        case (c)
          fjot_pkg::CH_QUOTE, fjot_pkg::CH_BSLASH, fjot_pkg::CH_SLASH: emit_utf8(c);
          fjot_pkg::CH_LOW_B: emit_utf8(fjot_pkg::CH_BS);
          fjot_pkg::CH_LOW_F: emit_utf8(fjot_pkg::CH_FF);
          fjot_pkg::CH_LOW_N: emit_utf8(fjot_pkg::CH_LF);
          fjot_pkg::CH_LOW_R: emit_utf8(fjot_pkg::CH_CR);
          fjot_pkg::CH_LOW_T: emit_utf8(fjot_pkg::CH_TAB);
          fjot_pkg::CH_LOW_U: begin
            hex_acc = '0;
            hex_cnt = '0;
            parse_ph = fjot_pkg::PH_HEX;
          end
          default: stop_on(fjot_pkg::ST_BAD_ESCAPE);
        endcase
      end
      fjot_pkg::PH_HEX, fjot_pkg::PH_LOHEX: begin
        h = hex_value(c);
        if (h < 0) begin
          stop_on(parse_ph == fjot_pkg::PH_HEX ? fjot_pkg::ST_BAD_HEX
                                               : fjot_pkg::ST_HALF_SURR);
        end else begin
          hex_acc = {hex_acc[11:0], h[3:0]};
          hex_cnt = hex_cnt + 3'd1;
          if (hex_cnt == 3'd4) begin
            hex_cnt = '0;
            if (parse_ph == fjot_pkg::PH_HEX) begin
              if (hex_acc[15:10] == fjot_pkg::SURR_HIGH_TAG) begin
                hi_surr = hex_acc[9:0];
                parse_ph = fjot_pkg::PH_LOBS;
              end else if (hex_acc[15:10] == fjot_pkg::SURR_LOW_TAG) begin
                stop_on(fjot_pkg::ST_HALF_SURR);
              end else begin
                parse_ph = fjot_pkg::PH_STR;
                emit_utf8(hex_acc);
              end
            end else if (hex_acc[15:10] != fjot_pkg::SURR_LOW_TAG) begin
              stop_on(fjot_pkg::ST_HALF_SURR);
            end else begin
              // pair joins as 0x10000 + high bits : low bits
              parse_ph = fjot_pkg::PH_STR;
              emit_utf8(32'h10000 + {hi_surr, hex_acc[9:0]});
            end
          end
        end
      end
      fjot_pkg::PH_LOBS: begin
        if (c == fjot_pkg::CH_BSLASH) parse_ph = fjot_pkg::PH_LOU;
        else stop_on(fjot_pkg::ST_HALF_SURR);
      end
      fjot_pkg::PH_LOU: begin
        if (c == fjot_pkg::CH_LOW_U) begin
          hex_acc = '0;
          hex_cnt = '0;
          parse_ph = fjot_pkg::PH_LOHEX;
        end else begin
          stop_on(fjot_pkg::ST_HALF_SURR);
        end
      end
      fjot_pkg::PH_COLON: begin
        if (!is_blank(c)) begin
          if (c == fjot_pkg::CH_COLON) parse_ph = fjot_pkg::PH_VALDUE;
          else stop_on(fjot_pkg::ST_NO_VALUE);
        end
      end
      fjot_pkg::PH_VALDUE: begin
        if (!is_blank(c)) begin
          if (c == fjot_pkg::CH_QUOTE) begin
            open_token(fjot_pkg::KIND_STR, fjot_pkg::PH_STR);
          end else if (c == fjot_pkg::CH_LBRACE || c == fjot_pkg::CH_LBRACK) begin
            stop_on(fjot_pkg::ST_NESTED);
          end else if (c == fjot_pkg::CH_COMMA || c == fjot_pkg::CH_RBRACE) begin
            stop_on(fjot_pkg::ST_NO_VALUE);
          end else begin
            open_token(fjot_pkg::KIND_BARE, fjot_pkg::PH_BARE);
            push_result(c, 1'b1, 1'b0);
            val_nonempty = 1'b1;
          end
        end
      end
      fjot_pkg::PH_BARE: begin
        if (c == fjot_pkg::CH_COMMA || c == fjot_pkg::CH_RBRACE || is_blank(c)) begin
          push_result(8'h00, 1'b0, 1'b1);
          if (c == fjot_pkg::CH_COMMA) parse_ph = fjot_pkg::PH_KEYDUE;
          else if (c == fjot_pkg::CH_RBRACE) parse_ph = fjot_pkg::PH_TAIL;
          else parse_ph = fjot_pkg::PH_AFTERVAL;
        end else begin
          push_result(c, 1'b1, 1'b0);
          val_nonempty = 1'b1;
        end
      end
      fjot_pkg::PH_AFTERVAL: begin
        if (!is_blank(c)) begin
          if (c == fjot_pkg::CH_COMMA) parse_ph = fjot_pkg::PH_KEYDUE;
          else if (c == fjot_pkg::CH_RBRACE) parse_ph = fjot_pkg::PH_TAIL;
          else stop_on(fjot_pkg::ST_SEP_EXPECTED);
        end
      end
      fjot_pkg::PH_TAIL: begin
        if (!is_blank(c)) stop_on(fjot_pkg::ST_TRAILING);
      end
      default: ;
    endcase
  endfunction

  // Status reported by the end mark, from where the text stopped
  function automatic fjot_pkg::status_t final_status();
    case (parse_ph)
      fjot_pkg::PH_START:      return fjot_pkg::ST_NOT_OBJECT;
      fjot_pkg::PH_OPENED,
      fjot_pkg::PH_KEYDUE:     return fjot_pkg::ST_KEY_EXPECTED;
      fjot_pkg::PH_STR:        return fjot_pkg::ST_UNCLOSED;
      fjot_pkg::PH_ESC:        return fjot_pkg::ST_CUT_ESCAPE;
      fjot_pkg::PH_HEX:        return fjot_pkg::ST_BAD_HEX;
      fjot_pkg::PH_LOBS,
      fjot_pkg::PH_LOU,
      fjot_pkg::PH_LOHEX:      return fjot_pkg::ST_HALF_SURR;
      fjot_pkg::PH_COLON,
      fjot_pkg::PH_VALDUE:     return fjot_pkg::ST_NO_VALUE;
      fjot_pkg::PH_BARE,
      fjot_pkg::PH_AFTERVAL:   return fjot_pkg::ST_SEP_EXPECTED;
      fjot_pkg::PH_TAIL:       return fjot_pkg::ST_DONE_OK;
      default:                 return sticky;
    endcase
  endfunction

  // Expected result transfers for one accepted input transfer
  function automatic void predict_tokens(fjot_pkg::in_item_t item);
    fjot_pkg::status_t   run_status;
    fjot_pkg::out_item_t r;
    run_buf.delete();
    if (item.end_of_text) begin
      run_status = final_status();
      push_result(8'h00, 1'b0, 1'b0);
      clear_parser();
    end else begin
      parse_byte(item.text_byte);
      if (run_buf.size() == 0) push_result(8'h00, 1'b0, 1'b0);
      run_status = sticky;
    end
    foreach (run_buf[k]) begin
      r = run_buf[k];
      r.status = run_status;
      r.last_of_run = (k == run_buf.size() - 1);
      expected_tokens.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Text generation
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] blank_char();
    case ($urandom_range(3))
      0:       return fjot_pkg::CH_SPACE;
      1:       return fjot_pkg::CH_TAB;
      2:       return fjot_pkg::CH_CR;
      default: return fjot_pkg::CH_LF;
    endcase
  endfunction

  function automatic void add_blanks();
    int n;
    n = ($urandom_range(2) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) text_buf.push_back(blank_char());
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(1) ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  function automatic void add_unicode(logic [15:0] v);
    text_buf.push_back(fjot_pkg::CH_BSLASH);
    text_buf.push_back(fjot_pkg::CH_LOW_U);
    text_buf.push_back(hex_char(v[15:12]));
    text_buf.push_back(hex_char(v[11:8]));
    text_buf.push_back(hex_char(v[7:4]));
    text_buf.push_back(hex_char(v[3:0]));
  endfunction

  // Quoted key or value: plain bytes, simple escapes, \u escapes and pairs
  function automatic void add_string();
    int          n;
    logic [7:0]  b;
    logic [15:0] v;
    text_buf.push_back(fjot_pkg::CH_QUOTE);
    n = $urandom_range(4);
    repeat (n) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          b = 8'($urandom_range(8'h20, 8'hFF));
          if (b == fjot_pkg::CH_QUOTE || b == fjot_pkg::CH_BSLASH) b = b + 8'd1;
          text_buf.push_back(b);
        end
        5: begin
          text_buf.push_back(fjot_pkg::CH_BSLASH);
          case ($urandom_range(7))
            0:       text_buf.push_back(fjot_pkg::CH_QUOTE);
            1:       text_buf.push_back(fjot_pkg::CH_BSLASH);
            2:       text_buf.push_back(fjot_pkg::CH_SLASH);
            3:       text_buf.push_back(fjot_pkg::CH_LOW_B);
            4:       text_buf.push_back(fjot_pkg::CH_LOW_F);
            5:       text_buf.push_back(fjot_pkg::CH_LOW_N);
            6:       text_buf.push_back(fjot_pkg::CH_LOW_R);
            default: text_buf.push_back(fjot_pkg::CH_LOW_T);
          endcase
        end
        6, 7: begin
          case ($urandom_range(2))
            0:       v = 16'($urandom_range(16'h7F));
            1:       v = 16'($urandom_range(16'h80, 16'h7FF));
            default: v = 16'($urandom_range(16'h800, 16'hFFFF));
          endcase
          // keep out of the surrogate range
          if (v[15:11] == 5'b11011) v[14] = ~v[14];
          add_unicode(v);
        end
        8: begin
          add_unicode({fjot_pkg::SURR_HIGH_TAG, 10'($urandom)});
          add_unicode({fjot_pkg::SURR_LOW_TAG, 10'($urandom)});
        end
        default: begin
          case ($urandom_range(2))
            0:       add_unicode(16'h0000);
            1:       add_unicode(16'hFFFF);
            default: begin
              add_unicode(16'hDBFF);
              add_unicode(16'hDFFF);
            end
          endcase
        end
      endcase
    end
    text_buf.push_back(fjot_pkg::CH_QUOTE);
  endfunction

  // Bare value: anything but separators and blanks, not opening a nest/string
  function automatic void add_bare();
    int         n;
    logic [7:0] b;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      do begin
        b = 8'($urandom);
      end while (b == fjot_pkg::CH_COMMA || b == fjot_pkg::CH_RBRACE || is_blank(b) ||
                 (i == 0 && (b == fjot_pkg::CH_LBRACE || b == fjot_pkg::CH_LBRACK ||
                             b == fjot_pkg::CH_QUOTE)));
      text_buf.push_back(b);
    end
  endfunction

  function automatic void build_object();
    int pairs;
    text_buf.delete();
    add_blanks();
    text_buf.push_back(fjot_pkg::CH_LBRACE);
    add_blanks();
    pairs = $urandom_range(2);
    for (int i = 0; i < pairs; i++) begin
      if (i > 0) begin
        text_buf.push_back(fjot_pkg::CH_COMMA);
        add_blanks();
      end
      add_string();
      add_blanks();
      text_buf.push_back(fjot_pkg::CH_COLON);
      add_blanks();
      if ($urandom_range(1)) add_string();
      else add_bare();
      add_blanks();
    end
    text_buf.push_back(fjot_pkg::CH_RBRACE);
    add_blanks();
  endfunction

  function automatic logic [7:0] fault_char();
    case ($urandom_range(10))
      0:       return fjot_pkg::CH_LBRACE;
      1:       return fjot_pkg::CH_LBRACK;
      2:       return fjot_pkg::CH_COMMA;
      3:       return fjot_pkg::CH_RBRACE;
      4:       return fjot_pkg::CH_QUOTE;
      5:       return fjot_pkg::CH_BSLASH;
      6:       return fjot_pkg::CH_COLON;
      7:       return 8'h01;
      8:       return 8'hFF;
      9:       return 8'h71;
      default: return 8'h78;
    endcase
  endfunction

  // One text plus its end mark; well formed in 45 of 100 cases, else cut, damaged or noise
  function automatic int queue_text();
    int                 mode;
    int                 cut;
    fjot_pkg::in_item_t it;
    build_object();
    mode = $urandom_range(99);
    if (mode < 8) begin
      text_buf.delete();
      repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom));
    end else if (mode < 30) begin
      cut = $urandom_range(text_buf.size() - 1);
      while (text_buf.size() > cut) text_buf.delete(text_buf.size() - 1);
    end else if (mode < 55) begin
      text_buf[$urandom_range(text_buf.size() - 1)] = fault_char();
    end
    foreach (text_buf[i]) begin
      it.text_byte = text_buf[i];
      it.end_of_text = 1'b0;
      text_items.push_back(it);
    end
    it.text_byte = 8'($urandom);
    it.end_of_text = 1'b1;
    text_items.push_back(it);
    texts_queued++;
    return text_buf.size() + 1;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued bytes, predicts on each accepted transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_tokens(in_data);
        items_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (text_items.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          in_data <= text_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, with an occasional long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_served <= 0;
    end else if (hold_served != hold_req) begin
      hold_served <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result transfer with the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      status_seen[out_data.status] = 1'b1;
      if (expected_tokens.size() == 0) begin
        $error("result transfer with no prediction pending");
        mismatches++;
      end else begin
        want = expected_tokens.pop_front();
        check_field("out_byte", want.out_byte, out_data.out_byte);
        check_field("has_byte", want.has_byte, out_data.has_byte);
        check_field("token_kind", want.token_kind, out_data.token_kind);
        check_field("token_end", want.token_end, out_data.token_end);
        check_field("status", want.status, out_data.status);
        check_field("last_of_run", want.last_of_run, out_data.last_of_run);
      end
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  task automatic wait_drained();
    do @(negedge clk);
    while (text_items.size() != 0 || in_valid || expected_tokens.size() != 0);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, bit long_hold);
    int added;
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    added = 0;
    while (added < PHASE_ITEMS) added += queue_text();
    if (long_hold) hold_req++;
    wait_drained();
  endtask

  initial begin
    string              opening;
    fjot_pkg::in_item_t it;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: 3- and 4-byte UTF-8 key via \u and a surrogate pair, bare value
    opening = "{\"\\u20AC\\uD83D\\uDE00\":x}";
    for (int i = 0; i < opening.len(); i++) begin
      it.text_byte = opening[i];
      it.end_of_text = 1'b0;
      text_items.push_back(it);
    end
    it.text_byte = 8'hFF;
    it.end_of_text = 1'b1;
    text_items.push_back(it);
    texts_queued++;
    wait_drained();

    run_phase(0, 0, 1'b1);
    run_phase(79, 0, 1'b0);
    run_phase(0, 79, 1'b0);
    run_phase(19, 19, 1'b0);

    repeat (END_CYCLES) @(posedge clk);
    $display("covered %0d texts, %0d input transfers, %0d result transfers",
             texts_queued, items_accepted, results_checked);
    $display("status codes seen (bit mask): %04h, mismatches: %0d", status_seen, mismatches);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/fjot_pkg.sv
rtl/core/fjot_utf8_enc.sv
rtl/core/flat_json_object_tokenizer_top.sv
tb/tb_flat_json_object_tokenizer_top.sv
